### rtl/virtio_mmio_net_register_file_macros.svh
// assertion macros shared by the register file modules
`ifndef VIRTIO_MMIO_NET_REGISTER_FILE_MACROS_SVH
`define VIRTIO_MMIO_NET_REGISTER_FILE_MACROS_SVH

// same-cycle implication, disabled in reset
`define VMNRF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("register file assertion failed");

// next-cycle implication, disabled in reset
`define VMNRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("register file assertion failed");

`endif

### rtl/vmnrf_pkg.sv
// types, constants and helpers of the virtio-mmio net register file
package vmnrf_pkg;

    localparam int NUM_QUEUES_DEF   = 2;
    localparam int QUEUE_DEPTH_DEF  = 256;
    localparam int WINDOW_BYTES_DEF = 512;

    localparam logic [1:0] TYPE_READ  = 2'd0;
    localparam logic [1:0] TYPE_WRITE = 2'd1;
    localparam logic [1:0] TYPE_DONE  = 2'd2;
    localparam logic [1:0] TYPE_FAIL  = 2'd3;

    localparam logic CFG_IDX_MAC    = 1'b0;
    localparam logic CFG_IDX_VENDOR = 1'b1;

    localparam logic [47:0] MAC_RESET    = 48'h0112_0000_5452;
    localparam logic [31:0] VENDOR_RESET = 32'h554d_4551;

    localparam logic [8:0] OFF_MAGIC       = 9'h000;
    localparam logic [8:0] OFF_VERSION     = 9'h004;
    localparam logic [8:0] OFF_DEVICE_ID   = 9'h008;
    localparam logic [8:0] OFF_VENDOR_ID   = 9'h00c;
    localparam logic [8:0] OFF_DEV_FEAT    = 9'h010;
    localparam logic [8:0] OFF_DEV_FEAT_SEL = 9'h014;
    localparam logic [8:0] OFF_DRV_FEAT    = 9'h020;
    localparam logic [8:0] OFF_DRV_FEAT_SEL = 9'h024;
    localparam logic [8:0] OFF_QUEUE_SEL   = 9'h030;
    localparam logic [8:0] OFF_QUEUE_MAX   = 9'h034;
    localparam logic [8:0] OFF_QUEUE_NUM   = 9'h038;
    localparam logic [8:0] OFF_QUEUE_READY = 9'h044;
    localparam logic [8:0] OFF_QUEUE_NOTIFY = 9'h050;
    localparam logic [8:0] OFF_IRQ_STATUS  = 9'h060;
    localparam logic [8:0] OFF_IRQ_ACK     = 9'h064;
    localparam logic [8:0] OFF_STATUS      = 9'h070;
    localparam logic [8:0] OFF_DESC_LO     = 9'h080;
    localparam logic [8:0] OFF_DESC_HI     = 9'h084;
    localparam logic [8:0] OFF_AVAIL_LO    = 9'h090;
    localparam logic [8:0] OFF_AVAIL_HI    = 9'h094;
    localparam logic [8:0] OFF_USED_LO     = 9'h0a0;
    localparam logic [8:0] OFF_USED_HI     = 9'h0a4;
    localparam logic [8:0] OFF_CFG_FIRST   = 9'h100;
    localparam logic [8:0] OFF_CFG_LAST    = 9'h105;

    localparam logic [31:0] MAGIC_VALUE   = 32'h7472_6976;
    localparam logic [31:0] VERSION_VALUE = 32'd2;
    localparam logic [31:0] DEVICE_ID_NET = 32'd1;

    localparam logic [63:0] HI_MASK      = 64'hffff_ffff_0000_0000;
    localparam logic [63:0] LO_MASK      = 64'h0000_0000_ffff_ffff;
    localparam logic [63:0] FEAT_OFFERED = 64'h0000_0001_0000_0020;

    localparam int ST_DRIVER_OK_BIT   = 2;
    localparam int ST_FEATURES_OK_BIT = 3;
    localparam int ST_FAILED_BIT      = 7;
    localparam int FEAT_VERSION_1_BIT = 32;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [8:0]  offset;
        logic [3:0]  access_length;
        logic [63:0] write_data;
    } t_req;

    typedef struct packed {
        logic [63:0] read_data;
        logic        notify_valid;
        logic        notify_queue;
        logic        interrupt_pending;
        logic        device_failed;
    } t_rsp;

    // byte lane enables for an access of len bytes
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                m[8*i +: 8] = 8'hff;
            end
        end
        return m;
    endfunction

endpackage

### rtl/vmnrf_core.sv
// register state, access decode and result logic of the register file
`include "virtio_mmio_net_register_file_macros.svh"

module vmnrf_core #(
    parameter int NUM_QUEUES   = vmnrf_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = vmnrf_pkg::QUEUE_DEPTH_DEF,
    parameter int WINDOW_BYTES = vmnrf_pkg::WINDOW_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  vmnrf_pkg::t_req   i_req,
    input  logic [47:0]       i_mac,
    input  logic [31:0]       i_vendor,
    output vmnrf_pkg::t_rsp   o_rsp
);
    import vmnrf_pkg::*;

    localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    logic [7:0]  r_device_status,   n_device_status;
    logic [31:0] r_dev_feat_sel,    n_dev_feat_sel;
    logic [31:0] r_drv_feat_sel,    n_drv_feat_sel;
    logic [63:0] r_accepted_feat,   n_accepted_feat;
    logic [31:0] r_irq_status,      n_irq_status;
    logic [31:0] r_queue_select,    n_queue_select;
    logic [15:0] r_queue_length  [NUM_QUEUES];
    logic [15:0] n_queue_length  [NUM_QUEUES];
    logic        r_queue_enabled [NUM_QUEUES];
    logic        n_queue_enabled [NUM_QUEUES];
    logic [63:0] r_desc_addr     [NUM_QUEUES];
    logic [63:0] n_desc_addr     [NUM_QUEUES];
    logic [63:0] r_avail_addr    [NUM_QUEUES];
    logic [63:0] n_avail_addr    [NUM_QUEUES];
    logic [63:0] r_used_addr     [NUM_QUEUES];
    logic [63:0] n_used_addr     [NUM_QUEUES];

    logic [QIDX_W-1:0] w_qidx;
    logic              w_qv;
    logic [12:0]       w_end;
    logic              w_ok;
    logic [63:0]       w_mask;
    logic [63:0]       w_v;
    logic [31:0]       w_v32;
    logic [63:0]       w_reg;
    logic [63:0]       w_mac64;
    logic [63:0]       w_rd;
    logic              w_nv;
    logic              w_nq;
    logic [7:0]        w_ns;

    assign w_qidx  = r_queue_select[QIDX_W-1:0];
    assign w_qv    = r_queue_select < 32'(NUM_QUEUES);
    assign w_end   = {4'b0, i_req.offset} + {9'b0, i_req.access_length};
    assign w_ok    = (i_req.access_length != 4'd0) && (i_req.access_length <= 4'd8)
                     && (w_end <= 13'(WINDOW_BYTES));
    assign w_mask  = byte_mask(i_req.access_length);
    assign w_v     = i_req.write_data & w_mask;
    assign w_v32   = w_v[31:0];
    assign w_mac64 = {16'b0, i_mac} >> {i_req.offset[2:0], 3'b000};
    assign w_ns    = w_v[7:0];

    // register read decode
    always_comb begin
        w_reg = '0;
        case (i_req.offset)
            OFF_MAGIC:        w_reg = {32'b0, MAGIC_VALUE};
            OFF_VERSION:      w_reg = {32'b0, VERSION_VALUE};
            OFF_DEVICE_ID:    w_reg = {32'b0, DEVICE_ID_NET};
            OFF_VENDOR_ID:    w_reg = {32'b0, i_vendor};
            OFF_DEV_FEAT: begin
                if (r_dev_feat_sel == 32'd0) begin
                    w_reg = FEAT_OFFERED & LO_MASK;
                end else if (r_dev_feat_sel == 32'd1) begin
                    w_reg = {32'b0, FEAT_OFFERED[63:32]};
                end
            end
            OFF_DEV_FEAT_SEL: w_reg = {32'b0, r_dev_feat_sel};
            OFF_DRV_FEAT: begin
                if (r_drv_feat_sel == 32'd0) begin
                    w_reg = r_accepted_feat & LO_MASK;
                end else if (r_drv_feat_sel == 32'd1) begin
                    w_reg = {32'b0, r_accepted_feat[63:32]};
                end
            end
            OFF_DRV_FEAT_SEL: w_reg = {32'b0, r_drv_feat_sel};
            OFF_QUEUE_SEL:    w_reg = {32'b0, r_queue_select};
            OFF_QUEUE_MAX:    w_reg = w_qv ? 64'(QUEUE_DEPTH) : 64'd0;
            OFF_QUEUE_NUM:    w_reg = w_qv ? {48'b0, r_queue_length[w_qidx]} : 64'd0;
            OFF_QUEUE_READY:  w_reg = {63'b0, w_qv && r_queue_enabled[w_qidx]};
            OFF_IRQ_STATUS:   w_reg = {32'b0, r_irq_status};
            OFF_STATUS:       w_reg = {56'b0, r_device_status};
            default:          w_reg = '0;
        endcase
    end

    // state update and result
    always_comb begin
        n_device_status = r_device_status;
        n_dev_feat_sel  = r_dev_feat_sel;
        n_drv_feat_sel  = r_drv_feat_sel;
        n_accepted_feat = r_accepted_feat;
        n_irq_status    = r_irq_status;
        n_queue_select  = r_queue_select;
        n_queue_length  = r_queue_length;
        n_queue_enabled = r_queue_enabled;
        n_desc_addr     = r_desc_addr;
        n_avail_addr    = r_avail_addr;
        n_used_addr     = r_used_addr;
        w_rd = '0;
        w_nv = 1'b0;
        w_nq = 1'b0;
        case (i_req.req_type)
            TYPE_READ: begin
                if (w_ok) begin
                    if (i_req.offset inside {[OFF_CFG_FIRST:OFF_CFG_LAST]}) begin
                        w_rd = w_mac64 & w_mask;
                    end else begin
                        w_rd = w_reg & w_mask;
                    end
                end
            end
            TYPE_WRITE: begin
                if (w_ok) begin
                    case (i_req.offset)
                        OFF_DEV_FEAT_SEL: n_dev_feat_sel = w_v32;
                        OFF_DRV_FEAT_SEL: n_drv_feat_sel = w_v32;
                        OFF_DRV_FEAT: begin
                            if (r_drv_feat_sel == 32'd0) begin
                                n_accepted_feat = {r_accepted_feat[63:32], w_v32};
                            end else if (r_drv_feat_sel == 32'd1) begin
                                n_accepted_feat = {w_v32, r_accepted_feat[31:0]};
                            end
                        end
                        OFF_QUEUE_SEL: n_queue_select = w_v32;
                        OFF_QUEUE_NUM: begin
                            if (w_qv && w_v != 64'd0 && w_v <= 64'(QUEUE_DEPTH)) begin
                                n_queue_length[w_qidx] = w_v[15:0];
                            end
                        end
                        OFF_QUEUE_READY: begin
                            if (w_qv) begin
                                n_queue_enabled[w_qidx] = w_v != 64'd0;
                            end
                        end
                        OFF_DESC_LO: begin
                            if (w_qv) n_desc_addr[w_qidx] = {r_desc_addr[w_qidx][63:32], w_v32};
                        end
                        OFF_DESC_HI: begin
                            if (w_qv) n_desc_addr[w_qidx] = {w_v32, r_desc_addr[w_qidx][31:0]};
                        end
                        OFF_AVAIL_LO: begin
                            if (w_qv) n_avail_addr[w_qidx] = {r_avail_addr[w_qidx][63:32], w_v32};
                        end
                        OFF_AVAIL_HI: begin
                            if (w_qv) n_avail_addr[w_qidx] = {w_v32, r_avail_addr[w_qidx][31:0]};
                        end
                        OFF_USED_LO: begin
                            if (w_qv) n_used_addr[w_qidx] = {r_used_addr[w_qidx][63:32], w_v32};
                        end
                        OFF_USED_HI: begin
                            if (w_qv) n_used_addr[w_qidx] = {w_v32, r_used_addr[w_qidx][31:0]};
                        end
                        OFF_QUEUE_NOTIFY: begin
                            if (w_v < 64'(NUM_QUEUES) && r_device_status[ST_DRIVER_OK_BIT]) begin
                                w_nv = 1'b1;
                                w_nq = w_v[0];
                            end
                        end
                        OFF_IRQ_ACK: n_irq_status = r_irq_status & ~w_v32;
                        OFF_STATUS: begin
                            if (w_ns == 8'd0) begin
                                // device reset
                                n_device_status = '0;
                                n_dev_feat_sel  = '0;
                                n_drv_feat_sel  = '0;
                                n_accepted_feat = '0;
                                n_irq_status    = '0;
                                n_queue_select  = '0;
                                for (int q = 0; q < NUM_QUEUES; q++) begin
                                    n_queue_length[q]  = '0;
                                    n_queue_enabled[q] = 1'b0;
                                    n_desc_addr[q]     = '0;
                                    n_avail_addr[q]    = '0;
                                    n_used_addr[q]     = '0;
                                end
                            end else begin
                                n_device_status = w_ns;
                                if (w_ns[ST_FEATURES_OK_BIT]
                                    && ((r_accepted_feat & ~FEAT_OFFERED) != 64'd0
                                        || !r_accepted_feat[FEAT_VERSION_1_BIT])) begin
                                    n_device_status[ST_FAILED_BIT] = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            TYPE_DONE: n_irq_status = r_irq_status | 32'd1;
            TYPE_FAIL: n_device_status[ST_FAILED_BIT] = 1'b1;
            default: ;
        endcase
    end

    assign o_rsp.read_data         = w_rd;
    assign o_rsp.notify_valid      = w_nv;
    assign o_rsp.notify_queue      = w_nq;
    assign o_rsp.interrupt_pending = n_irq_status != 32'd0;
    assign o_rsp.device_failed     = n_device_status[ST_FAILED_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_status <= '0;
            r_dev_feat_sel  <= '0;
            r_drv_feat_sel  <= '0;
            r_accepted_feat <= '0;
            r_irq_status    <= '0;
            r_queue_select  <= '0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_queue_length[q]  <= '0;
                r_queue_enabled[q] <= 1'b0;
                r_desc_addr[q]     <= '0;
                r_avail_addr[q]    <= '0;
                r_used_addr[q]     <= '0;
            end
        end else if (i_fire) begin
            r_device_status <= n_device_status;
            r_dev_feat_sel  <= n_dev_feat_sel;
            r_drv_feat_sel  <= n_drv_feat_sel;
            r_accepted_feat <= n_accepted_feat;
            r_irq_status    <= n_irq_status;
            r_queue_select  <= n_queue_select;
            r_queue_length  <= n_queue_length;
            r_queue_enabled <= n_queue_enabled;
            r_desc_addr     <= n_desc_addr;
            r_avail_addr    <= n_avail_addr;
            r_used_addr     <= n_used_addr;
        end
    end

    `VMNRF_ASSERT_NEXT(a_done_sets_irq, i_clk, i_rst_n,
        i_fire && i_req.req_type == TYPE_DONE, r_irq_status[0])
    `VMNRF_ASSERT_NEXT(a_fail_sets_failed, i_clk, i_rst_n,
        i_fire && i_req.req_type == TYPE_FAIL, r_device_status[ST_FAILED_BIT])
    `VMNRF_ASSERT_NEXT(a_idle_holds_state, i_clk, i_rst_n, !i_fire,
        $stable(r_device_status) && $stable(r_irq_status) && $stable(r_queue_select))

endmodule

### rtl/virtio_mmio_net_register_file.sv
// top level of the virtio-mmio net register file: beat registers and config
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------------
//  in      | in  | i_in_valid / o_in_ready | req_type, offset, access_length, write_data
//  out     | out | o_out_valid / i_out_ready | read_data, notify, interrupt, failed
//  cfg     | in  | i_cfg_we                | i_cfg_index, i_cfg_wdata
//
//  one beat per cycle sustained while the output is not stalled; each beat passes two registers
//  beat register -> decode and state update -> result register, state written at that edge
//  synchronous reset clears state, config returns to default MAC and vendor code
//  a stalled output holds the result register; the input register still takes one beat
`include "virtio_mmio_net_register_file_macros.svh"

module virtio_mmio_net_register_file #(
    parameter int NUM_QUEUES   = vmnrf_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH  = vmnrf_pkg::QUEUE_DEPTH_DEF,
    parameter int WINDOW_BYTES = vmnrf_pkg::WINDOW_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [8:0]  i_offset,
    input  logic [3:0]  i_access_length,
    input  logic [63:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_read_data,
    output logic        o_notify_valid,
    output logic        o_notify_queue,
    output logic        o_interrupt_pending,
    output logic        o_device_failed,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [47:0] i_cfg_wdata
);
    import vmnrf_pkg::*;

    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;
    logic [47:0] r_mac;
    logic [31:0] r_vendor;
    logic        w_fire;
    logic        w_in_take;
    t_rsp        w_rsp;

    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;
    assign w_in_take  = i_in_valid && o_in_ready;

    vmnrf_core #(
        .NUM_QUEUES   (NUM_QUEUES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_req    (r_in),
        .i_mac    (r_mac),
        .i_vendor (r_vendor),
        .o_rsp    (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.req_type      <= i_req_type;
            r_in.offset        <= i_offset;
            r_in.access_length <= i_access_length;
            r_in.write_data    <= i_write_data;
        end
        if (w_fire) begin
            r_out <= w_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac    <= MAC_RESET;
            r_vendor <= VENDOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IDX_MAC:    r_mac    <= i_cfg_wdata;
                CFG_IDX_VENDOR: r_vendor <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_out.read_data;
    assign o_notify_valid      = r_out.notify_valid;
    assign o_notify_queue      = r_out.notify_queue;
    assign o_interrupt_pending = r_out.interrupt_pending;
    assign o_device_failed     = r_out.device_failed;

    `VMNRF_ASSERT_NEXT(a_fire_fills_out, i_clk, i_rst_n, w_fire, r_out_valid)
    `VMNRF_ASSERT_IMPL(a_notify_no_data, i_clk, i_rst_n,
        r_out_valid && r_out.notify_valid, r_out.read_data == 64'd0)
    `VMNRF_ASSERT_IMPL(a_queue_needs_notify, i_clk, i_rst_n,
        r_out_valid && !r_out.notify_valid, !r_out.notify_queue)

endmodule
